@@ design/hfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hfr_pkg;

    localparam int unsigned WordWidth   = 16;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned StatusWidth = 3;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned NumOpcodes  = 6;

    // Register indexes on the configuration port.
    localparam logic [CfgIdxWidth-1:0] REG_HEADER   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_A = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_B = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_C = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_D = 3'd4;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_E = 3'd5;
    localparam logic [CfgIdxWidth-1:0] REG_OPCODE_F = 3'd6;

    // Status codes carried with every result word.
    localparam logic [StatusWidth-1:0] ST_BUSY    = 3'd0;
    localparam logic [StatusWidth-1:0] ST_DONE    = 3'd1;
    localparam logic [StatusWidth-1:0] ST_BAD_HDR = 3'd2;
    localparam logic [StatusWidth-1:0] ST_BAD_OP  = 3'd3;
    localparam logic [StatusWidth-1:0] ST_SPARE   = 3'd4;
    localparam logic [StatusWidth-1:0] ST_CHKSUM  = 3'd5;

    // Frame phases, one for each word of the frame.
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_OPCODE = 4'd1;
    localparam logic [3:0] PH_DATA1  = 4'd2;
    localparam logic [3:0] PH_DATA2  = 4'd3;
    localparam logic [3:0] PH_DATA3  = 4'd4;
    localparam logic [3:0] PH_SPARE  = 4'd5;
    localparam logic [3:0] PH_CHKSUM = 4'd6;
    localparam logic [3:0] PH_RES1   = 4'd7;
    localparam logic [3:0] PH_RES2   = 4'd8;
    localparam logic [3:0] PH_RES3   = 4'd9;
    localparam logic [3:0] PH_RES4   = 4'd10;
    localparam logic [3:0] PH_RES5   = 4'd11;
    localparam logic [3:0] PH_RES6   = 4'd12;
    localparam logic [3:0] PH_RES7   = 4'd13;

    localparam logic [WordWidth-1:0] SPARE_VALUE = 16'h0000;

    typedef logic [WordWidth-1:0] word_t;

    typedef struct packed {
        logic [StatusWidth-1:0] status;
        word_t                  opcode_out;
        word_t                  data_one;
        word_t                  data_two;
        word_t                  data_three;
    } result_t;

    typedef struct packed {
        word_t                  header_word;
        word_t [NumOpcodes-1:0] opcodes;
    } cfg_t;

endpackage

`default_nettype wire

@@ design/hfr_rx_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface hfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       timeout_seen;

    modport source (output valid, output rx_byte, output timeout_seen, input ready);
    modport sink   (input valid, input rx_byte, input timeout_seen, output ready);
endinterface

`default_nettype wire

@@ design/hfr_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface hfr_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] opcode_out;
    logic [15:0] data_one;
    logic [15:0] data_two;
    logic [15:0] data_three;

    modport source (output valid, output status, output opcode_out, output data_one,
                    output data_two, output data_three, input ready);
    modport sink   (input valid, input status, input opcode_out, input data_one,
                    input data_two, input data_three, output ready);
endinterface

`default_nettype wire

@@ design/hfr_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfr_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             timeout_seen,
    input  wire hfr_pkg::cfg_t    cfg,
    output hfr_pkg::result_t      result
);
    import hfr_pkg::*;

    logic [3:0]           phase_reg,  phase_next;
    logic                 odd_reg,    odd_next;
    logic [ByteWidth-1:0] prev_reg;
    word_t                sum_reg,    sum_next;
    word_t                opcode_reg, opcode_next;
    word_t                data1_reg,  data1_next;
    word_t                data2_reg,  data2_next;
    word_t                data3_reg,  data3_next;

    logic [3:0] phase_eff;
    word_t      sum_eff;
    logic       odd_eff;
    word_t      w;
    logic       op_ok;

    always_comb
    begin
        op_ok = 1'b0;
        for (int i = 0; i < NumOpcodes; i++)
        begin
            if (cfg.opcodes[i] == w)
            begin
                op_ok = 1'b1;
            end
        end
    end

    assign w         = {rx_byte, prev_reg};
    assign phase_eff = timeout_seen ? PH_HEADER : phase_reg;
    assign odd_eff   = timeout_seen ? 1'b0 : odd_reg;
    assign sum_eff   = timeout_seen ? '0 : sum_reg;

    always_comb
    begin
        phase_next  = phase_eff;
        sum_next    = sum_eff;
        opcode_next = opcode_reg;
        data1_next  = data1_reg;
        data2_next  = data2_reg;
        data3_next  = data3_reg;
        result      = '0;
        result.status = ST_BUSY;
        if (!odd_eff)
        begin
            odd_next = 1'b1;
        end
        else
        begin
            odd_next = 1'b0;
            case (phase_eff)
                PH_OPCODE:
                begin
                    if (op_ok)
                    begin
                        sum_next    = sum_eff + w;
                        opcode_next = w;
                        phase_next  = PH_DATA1;
                    end
                    else
                    begin
                        phase_next    = PH_HEADER;
                        sum_next      = '0;
                        result.status = ST_BAD_OP;
                    end
                end
                PH_DATA1:
                begin
                    sum_next   = sum_eff + w;
                    data1_next = w;
                    phase_next = PH_DATA2;
                end
                PH_DATA2:
                begin
                    sum_next   = sum_eff + w;
                    data2_next = w;
                    phase_next = PH_DATA3;
                end
                PH_DATA3:
                begin
                    sum_next   = sum_eff + w;
                    data3_next = w;
                    phase_next = PH_SPARE;
                end
                PH_SPARE:
                begin
                    if (w == SPARE_VALUE)
                    begin
                        sum_next   = sum_eff + w;
                        phase_next = PH_CHKSUM;
                    end
                    else
                    begin
                        phase_next    = PH_HEADER;
                        sum_next      = '0;
                        result.status = ST_SPARE;
                    end
                end
                PH_CHKSUM:
                begin
                    if (w == sum_eff)
                    begin
                        phase_next = PH_RES1;
                    end
                    else
                    begin
                        phase_next    = PH_HEADER;
                        sum_next      = '0;
                        result.status = ST_CHKSUM;
                    end
                end
                PH_RES1, PH_RES2, PH_RES3, PH_RES4, PH_RES5, PH_RES6:
                begin
                    phase_next = phase_eff + 4'd1;
                end
                PH_RES7:
                begin
                    phase_next        = PH_HEADER;
                    sum_next          = '0;
                    result.status     = ST_DONE;
                    result.opcode_out = opcode_reg;
                    result.data_one   = data1_reg;
                    result.data_two   = data2_reg;
                    result.data_three = data3_reg;
                end
                default:
                begin
                    if (w == cfg.header_word)
                    begin
                        sum_next   = sum_eff + w;
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        phase_next    = PH_HEADER;
                        sum_next      = '0;
                        result.status = ST_BAD_HDR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            odd_reg    <= 1'b0;
            prev_reg   <= '0;
            sum_reg    <= '0;
            opcode_reg <= '0;
            data1_reg  <= '0;
            data2_reg  <= '0;
            data3_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            odd_reg    <= odd_next;
            prev_reg   <= rx_byte;
            sum_reg    <= sum_next;
            opcode_reg <= opcode_next;
            data1_reg  <= data1_next;
            data2_reg  <= data2_next;
            data3_reg  <= data3_next;
        end
    end

endmodule

`default_nettype wire

@@ design/host_frame_receiver.sv @@
// host_frame_receiver
//
// Receives a byte stream on rx_ch (rx_byte plus a timeout_seen flag that
// restarts frame reception before the byte is handled) and returns one result
// word on res_ch for every byte accepted: a status code and, when a frame has
// just completed, its opcode and three data words (zero otherwise).
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; index 0 is the header word, indexes 1 to 6 the allowed opcodes.
// A byte is decoded and the frame state updated in the cycle it is accepted;
// its result is registered into the output stage that drives res_ch, and one
// byte can be accepted every cycle while the skid stage is empty.
// The result register is backed by a one-word skid stage: if the receiver on
// res_ch stalls, one further byte is still taken, after which rx_ch.ready
// stays low until the skid word has moved on into the output stage.
// Reset clears the configuration registers, the frame state (header hunting)
// and both output stages' valid flags; rx_ch.ready is high straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module host_frame_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hfr_rx_if.sink                             rx_ch,
    hfr_res_if.source                          res_ch,
    input  wire logic                          cfg_we,
    input  wire logic [hfr_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [hfr_pkg::WordWidth-1:0]   cfg_data
);
    import hfr_pkg::*;

    cfg_t    cfg_reg;
    result_t new_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;

    assign rx_ch.ready = !skid_valid_reg;
    assign accept      = rx_ch.valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER:   cfg_reg.header_word <= cfg_data;
                REG_OPCODE_A: cfg_reg.opcodes[0]  <= cfg_data;
                REG_OPCODE_B: cfg_reg.opcodes[1]  <= cfg_data;
                REG_OPCODE_C: cfg_reg.opcodes[2]  <= cfg_data;
                REG_OPCODE_D: cfg_reg.opcodes[3]  <= cfg_data;
                REG_OPCODE_E: cfg_reg.opcodes[4]  <= cfg_data;
                REG_OPCODE_F: cfg_reg.opcodes[5]  <= cfg_data;
                default:      ;
            endcase
        end
    end

    hfr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .rx_byte      (rx_ch.rx_byte),
        .timeout_seen (rx_ch.timeout_seen),
        .cfg          (cfg_reg),
        .result       (new_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_ch.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || res_ch.ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res_ch.ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || res_ch.ready)
            begin
                out_reg <= new_result;
            end
            else
            begin
                skid_reg <= new_result;
            end
        end
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.status     = out_reg.status;
    assign res_ch.opcode_out = out_reg.opcode_out;
    assign res_ch.data_one   = out_reg.data_one;
    assign res_ch.data_two   = out_reg.data_two;
    assign res_ch.data_three = out_reg.data_three;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output stage is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && !res_ch.ready) |=> skid_valid_reg)
        else $error("word accepted under a stall was not kept in the skid stage");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> (res_ch.status <= ST_CHKSUM))
        else $error("status code out of range");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.status != ST_DONE) |->
        (res_ch.opcode_out == '0 && res_ch.data_one == '0 &&
         res_ch.data_two == '0 && res_ch.data_three == '0))
        else $error("frame fields non-zero outside a finished frame");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import hfr_pkg::*;

    localparam int unsigned FRAME_WORDS = 14;
    localparam int unsigned FRAME_BYTES = 2 * FRAME_WORDS;
    localparam int unsigned BYTE_TARGET = 1650;
    localparam int unsigned CONFIG_PHASES = 6;

    typedef enum {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_BAD_OPCODE,
        FR_BAD_SPARE,
        FR_BAD_CHECKSUM,
        FR_TRUNCATED
    } frame_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    word_t                  cfg_data = '0;

    hfr_rx_if  rx_ch ();
    hfr_res_if res_ch ();

    host_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_ch     (rx_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the receiver: configuration and frame state.
    word_t      cfg_header;
    word_t      cfg_ops [NumOpcodes];
    logic [3:0] rx_phase;
    logic       rx_odd;
    logic [7:0] rx_prev;
    word_t      rx_sum;
    word_t      rx_opcode;
    word_t      rx_data [3];

    result_t     results_due [$];
    word_t       frame_words [FRAME_WORDS];
    word_t       next_header;
    word_t       next_ops [NumOpcodes];
    int unsigned bytes_sent = 0;
    int unsigned errors = 0;
    int unsigned hold_cycles = 0;
    bit          sender_gaps = 1'b0;
    bit          sink_stalls = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void frame_state_reset();
        cfg_header = '0;
        for (int i = 0; i < NumOpcodes; i++)
        begin
            cfg_ops[i] = '0;
        end
        rx_phase = PH_HEADER;
        rx_odd = 1'b0;
        rx_prev = '0;
        rx_sum = '0;
        rx_opcode = '0;
        for (int i = 0; i < 3; i++)
        begin
            rx_data[i] = '0;
        end
    endfunction

    function automatic bit opcode_known(word_t w);
        for (int i = 0; i < NumOpcodes; i++)
        begin
            if (cfg_ops[i] == w)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic result_t receive_byte(logic [7:0] b, logic restart);
        result_t r;
        word_t   w;
        r = '0;
        r.status = ST_BUSY;
        if (restart)
        begin
            rx_phase = PH_HEADER;
            rx_odd = 1'b0;
            rx_sum = '0;
        end
        if (!rx_odd)
        begin
            rx_odd = 1'b1;
        end
        else
        begin
            rx_odd = 1'b0;
            w = {b, rx_prev};
            if (rx_phase == PH_OPCODE)
            begin
                if (opcode_known(w))
                begin
                    rx_sum = rx_sum + w;
                    rx_opcode = w;
                    rx_phase = PH_DATA1;
                end
                else
                begin
                    r.status = ST_BAD_OP;
                end
            end
            else if (rx_phase >= PH_DATA1 && rx_phase <= PH_DATA3)
            begin
                rx_sum = rx_sum + w;
                rx_data[rx_phase - PH_DATA1] = w;
                rx_phase = rx_phase + 4'd1;
            end
            else if (rx_phase == PH_SPARE)
            begin
                if (w == SPARE_VALUE)
                begin
                    rx_sum = rx_sum + w;
                    rx_phase = PH_CHKSUM;
                end
                else
                begin
                    r.status = ST_SPARE;
                end
            end
            else if (rx_phase == PH_CHKSUM)
            begin
                if (w == rx_sum)
                begin
                    rx_phase = PH_RES1;
                end
                else
                begin
                    r.status = ST_CHKSUM;
                end
            end
            else if (rx_phase >= PH_RES1 && rx_phase < PH_RES7)
            begin
                rx_phase = rx_phase + 4'd1;
            end
            else if (rx_phase == PH_RES7)
            begin
                r.status = ST_DONE;
                r.opcode_out = rx_opcode;
                r.data_one = rx_data[0];
                r.data_two = rx_data[1];
                r.data_three = rx_data[2];
            end
            else if (w == cfg_header)
            begin
                rx_sum = rx_sum + w;
                rx_phase = PH_OPCODE;
            end
            else
            begin
                r.status = ST_BAD_HDR;
            end
            // A finished frame and every rejection send the receiver back to hunting.
            if (r.status != ST_BUSY)
            begin
                rx_phase = PH_HEADER;
                rx_sum = '0;
            end
        end
        rx_prev = b;
        return r;
    endfunction

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t random_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'h0000;
        end
        if (r == 1)
        begin
            return 16'hFFFF;
        end
        return word_t'($urandom);
    endfunction

    function automatic word_t nonzero_word();
        return word_t'($urandom_range(1, 65535));
    endfunction

    function automatic void build_frame(word_t opcode, word_t d1, word_t d2, word_t d3);
        frame_words[0] = cfg_header;
        frame_words[1] = opcode;
        frame_words[2] = d1;
        frame_words[3] = d2;
        frame_words[4] = d3;
        frame_words[5] = SPARE_VALUE;
        frame_words[6] = cfg_header + opcode + d1 + d2 + d3 + SPARE_VALUE;
        for (int i = 7; i < FRAME_WORDS; i++)
        begin
            frame_words[i] = random_word();
        end
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (results_due.size() == 0)
        begin
            $error("result word with no byte waiting for it, status %0d", res_ch.status);
            errors++;
        end
        else
        begin
            want = results_due.pop_front();
            compare_field("status", 16'(want.status), 16'(res_ch.status));
            compare_field("opcode_out", want.opcode_out, res_ch.opcode_out);
            compare_field("data_one", want.data_one, res_ch.data_one);
            compare_field("data_two", want.data_two, res_ch.data_two);
            compare_field("data_three", want.data_three, res_ch.data_three);
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                check_result();
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end
            else if (stall != 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                stall = sink_stalls ? idle_length() : 0;
                res_ch.ready <= (stall == 0);
                if (stall != 0)
                begin
                    stall--;
                end
            end
        end
    end

    // The valid line is left high after a byte is taken, so that a following
    // byte can go straight out; anything that stops sending must lower it.
    task automatic send_byte(logic [7:0] b, logic restart);
        int unsigned gap;
        gap = sender_gaps ? idle_length() : 0;
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.timeout_seen <= restart;
        do @(posedge clk); while (rx_ch.ready !== 1'b1);
        results_due.push_back(receive_byte(b, restart));
        bytes_sent++;
    endtask

    task automatic send_words(int unsigned first_byte, int unsigned end_byte, logic restart);
        word_t w;
        for (int unsigned i = first_byte; i < end_byte; i++)
        begin
            w = frame_words[i / 2];
            send_byte((i % 2 == 0) ? w[7:0] : w[15:8], restart && (i == first_byte));
        end
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic apply_config(logic [NumOpcodes:0] mask);
        wait_idle();
        for (int i = 0; i <= NumOpcodes; i++)
        begin
            if (mask[i])
            begin
                cfg_we <= 1'b1;
                if (i == 0)
                begin
                    cfg_index <= REG_HEADER;
                    cfg_data <= next_header;
                end
                else
                begin
                    cfg_index <= REG_OPCODE_A + CfgIdxWidth'(i - 1);
                    cfg_data <= next_ops[i - 1];
                end
                @(posedge clk);
                if (i == 0)
                begin
                    cfg_header = next_header;
                end
                else
                begin
                    cfg_ops[i - 1] = next_ops[i - 1];
                end
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_frame(frame_kind_t kind, logic restart);
        word_t       w;
        int unsigned nbytes;
        build_frame(cfg_ops[$urandom_range(0, NumOpcodes - 1)],
                    random_word(), random_word(), random_word());
        nbytes = FRAME_BYTES;
        case (kind)
            FR_BAD_HEADER:
            begin
                frame_words[0] = cfg_header ^ nonzero_word();
                nbytes = 2;
            end
            FR_BAD_OPCODE:
            begin
                do w = random_word(); while (opcode_known(w));
                frame_words[1] = w;
                nbytes = 4;
            end
            FR_BAD_SPARE:
            begin
                frame_words[5] = nonzero_word();
                nbytes = 12;
            end
            FR_BAD_CHECKSUM:
            begin
                frame_words[6] = frame_words[6] ^ nonzero_word();
                nbytes = 14;
            end
            FR_TRUNCATED:
            begin
                nbytes = $urandom_range(1, FRAME_BYTES - 1);
            end
            default:
            begin
            end
        endcase
        send_words(0, nbytes, restart);
    endtask

    task automatic test_default_config();
        build_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_words(0, FRAME_BYTES, 1'b0);
        wait_idle();
    endtask

    task automatic test_extreme_words();
        next_header = 16'hFFFF;
        for (int i = 0; i < NumOpcodes; i++)
        begin
            next_ops[i] = 16'hFFFF;
        end
        apply_config('1);
        build_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_words(0, FRAME_BYTES, 1'b1);
        wait_idle();
    endtask

    task automatic test_rejections();
        next_header = 16'hA55A;
        next_ops[0] = 16'h0001;
        next_ops[1] = 16'h0100;
        next_ops[2] = 16'h8000;
        next_ops[3] = 16'h7FFF;
        next_ops[4] = 16'h1234;
        next_ops[5] = 16'h1234;
        apply_config('1);
        frame_words[0] = ~cfg_header;
        send_words(0, 2, 1'b0);
        // One stray byte puts the header across two pairs, and both are dropped.
        build_frame(cfg_ops[5], 16'h0000, 16'hFFFF, 16'h8000);
        send_byte(8'h00, 1'b0);
        send_words(0, 4, 1'b0);
        send_words(0, 4, 1'b1);
        frame_words[1] = 16'h0002;
        send_words(0, 4, 1'b1);
        build_frame(cfg_ops[0], 16'h1111, 16'h2222, 16'h3333);
        frame_words[5] = 16'h8000;
        send_words(0, 12, 1'b0);
        build_frame(cfg_ops[3], 16'h4444, 16'h5555, 16'h6666);
        frame_words[6] = frame_words[6] + 16'h0001;
        send_words(0, 14, 1'b0);
        // A timeout on the second byte of a word makes that byte the first of a new word.
        send_byte(cfg_header[7:0], 1'b0);
        send_byte(cfg_header[7:0], 1'b1);
        send_byte(cfg_header[15:8], 1'b0);
        wait_idle();
    endtask

    task automatic test_result_backpressure();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        build_frame(cfg_ops[2], random_word(), random_word(), random_word());
        hold_cycles = 150;
        send_words(0, FRAME_BYTES, 1'b1);
        wait_idle();
    endtask

    task automatic test_sender_pause();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        build_frame(cfg_ops[1], random_word(), random_word(), random_word());
        send_words(0, 9, 1'b1);
        wait_idle();
        send_words(9, FRAME_BYTES, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned r;
        bit          cut_short;
        cut_short = 1'b0;
        for (int p = 0; p < CONFIG_PHASES; p++)
        begin
            next_header = word_t'($urandom);
            for (int i = 0; i < NumOpcodes; i++)
            begin
                next_ops[i] = random_word();
            end
            case (p)
                0:
                begin
                    next_header = 16'hFFFF;
                    for (int i = 0; i < NumOpcodes; i++)
                    begin
                        next_ops[i] = 16'h0000;
                    end
                end
                2: next_ops[3] = next_ops[1];
                4:
                begin
                    next_header = 16'h0000;
                    next_ops[0] = 16'h0000;
                    next_ops[5] = 16'hFFFF;
                end
                default:
                begin
                end
            endcase
            apply_config((p == 3) ? 7'($urandom_range(1, 127)) : '1);
            while (bytes_sent < BYTE_TARGET * (p + 1) / CONFIG_PHASES)
            begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                    end
                    cut_short = 1'b1;
                end
                else
                begin
                    send_random_frame((r < 70) ? FR_GOOD :
                                      (r < 75) ? FR_BAD_HEADER :
                                      (r < 80) ? FR_BAD_OPCODE :
                                      (r < 84) ? FR_BAD_SPARE :
                                      (r < 88) ? FR_BAD_CHECKSUM : FR_TRUNCATED,
                                      (cut_short && $urandom_range(0, 1) == 1) ||
                                      $urandom_range(0, 15) == 0);
                    cut_short = (r >= 88);
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_idle();
                end
            end
        end
    endtask

    initial
    begin
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        rx_ch.timeout_seen = 1'b0;
        frame_state_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_extreme_words();
        test_rejections();
        test_result_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_idle();
        repeat (5) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/hfr_pkg.sv
design/hfr_rx_if.sv
design/hfr_res_if.sv
design/hfr_parser.sv
design/host_frame_receiver.sv
test/testbench.sv
